[src/lsfb_pkg.sv]
package lsfb_pkg;

    localparam int PIXEL_SLOTS_DEF = 64;

    // Field widths fixed by the request and result formats.
    localparam int LEN_W   = 7;
    localparam int ORDER_W = 2;
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 16;
    localparam int SUM_W   = IDX_W + 1;
    localparam int LEVEL_W = 8;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LEN_W;
    localparam int IN_DATA_W  = 2 * IDX_W + 4 * LEVEL_W;

    localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SHOW  = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_GRB    = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_RGB    = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_GRBW   = 2'd2;
    localparam logic [ORDER_W-1:0] ORDER_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 1'd1;

    localparam logic [LEN_W-1:0]   STRIP_LENGTH_RST  = 7'd64;
    localparam logic [ORDER_W-1:0] CHANNEL_ORDER_RST = ORDER_GRB;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SHOW_RD,
        ST_SHOW_LD
    } state_t;

    typedef struct packed {
        logic load;
        logic cnt_clr;
        logic clear_valid;
        logic fill_we;
        logic cnt_inc;
        logic show_rd;
        logic show_ld;
    } cmd_t;

    typedef struct packed {
        logic write_ok;
        logic fill_last;
        logic show_last;
        logic out_free;
    } status_t;

    function automatic logic [WORD_W-1:0] pack_word(
        input logic [ORDER_W-1:0] order,
        input logic [LEVEL_W-1:0] r,
        input logic [LEVEL_W-1:0] g,
        input logic [LEVEL_W-1:0] b,
        input logic [LEVEL_W-1:0] w
    );
        logic [WORD_W-1:0] word;
        case (order)
            ORDER_GRB:  word = {8'h00, g, r, b};
            ORDER_RGB:  word = {8'h00, r, g, b};
            ORDER_GRBW: word = {w, g, r, b};
            default:    word = '0;
        endcase
        return word;
    endfunction

endpackage

[src/lsfb_ctrl.sv]
module lsfb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic [lsfb_pkg::REQ_W-1:0]    req_type,
    input  lsfb_pkg::status_t             status,
    output logic                          s_tready,
    output lsfb_pkg::cmd_t                cmd
);
    import lsfb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_CLEAR || req_type == REQ_SHOW)
                    begin
                        state_next = ST_SHOW_RD;
                    end
                    else if (status.write_ok)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW_RD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_SHOW_LD;
                end
            end
            ST_SHOW_LD:
            begin
                state_next = status.show_last ? ST_IDLE : ST_SHOW_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (req_type == REQ_CLEAR || req_type == REQ_SHOW)
                    begin
                        cmd.cnt_clr     = 1'b1;
                        cmd.clear_valid = (req_type == REQ_CLEAR);
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_we = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            ST_SHOW_RD:
            begin
                cmd.show_rd = status.out_free;
            end
            ST_SHOW_LD:
            begin
                cmd.show_ld = 1'b1;
                cmd.cnt_inc = !status.show_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/lsfb_datapath.sv]
module lsfb_datapath #(
    parameter int PIXEL_SLOTS = lsfb_pkg::PIXEL_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsfb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [lsfb_pkg::REQ_W-1:0]        req_type,
    input  logic [lsfb_pkg::IN_DATA_W-1:0]    s_tdata,
    input  lsfb_pkg::cmd_t                    cmd,
    output lsfb_pkg::status_t                 status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [lsfb_pkg::WORD_W-1:0]       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import lsfb_pkg::*;

    localparam int ADDR_W = (PIXEL_SLOTS > 1) ? $clog2(PIXEL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PIXEL_SLOTS + 1);
    localparam logic [LEN_W-1:0] SLOTS_LEN = LEN_W'(PIXEL_SLOTS);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(PIXEL_SLOTS - 1);

    logic [LEN_W-1:0]   strip_len_reg;
    logic [ORDER_W-1:0] order_reg;

    logic [IDX_W-1:0]   first_pix;
    logic [IDX_W-1:0]   run_len;
    logic [LEVEL_W-1:0] red_lvl, green_lvl, blue_lvl, white_lvl;

    logic [LEN_W-1:0]   limit;
    logic [SUM_W-1:0]   limit_ext;
    logic [SUM_W-1:0]   start_ext;
    logic [SUM_W-1:0]   end_sum;
    logic [LEN_W-1:0]   end_val;

    logic [WORD_W-1:0]  word_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   end_reg;
    logic [ADDR_W-1:0]  addr;

    logic [WORD_W-1:0]  mem [PIXEL_SLOTS];
    logic [PIXEL_SLOTS-1:0] valid_reg;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               rd_valid_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_data_reg;
    logic               out_wide_reg;
    logic               out_last_reg;

    assign first_pix = s_tdata[IDX_W-1:0];
    assign run_len   = s_tdata[2*IDX_W-1:IDX_W];
    assign red_lvl   = s_tdata[2*IDX_W+LEVEL_W-1:2*IDX_W];
    assign green_lvl = s_tdata[2*IDX_W+2*LEVEL_W-1:2*IDX_W+LEVEL_W];
    assign blue_lvl  = s_tdata[2*IDX_W+3*LEVEL_W-1:2*IDX_W+2*LEVEL_W];
    assign white_lvl = s_tdata[2*IDX_W+4*LEVEL_W-1:2*IDX_W+3*LEVEL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_len_reg <= STRIP_LENGTH_RST;
            order_reg     <= CHANNEL_ORDER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STRIP_LENGTH:  strip_len_reg <= cfg_data;
                CFG_CHANNEL_ORDER: order_reg     <= cfg_data[ORDER_W-1:0];
                default:           strip_len_reg <= strip_len_reg;
            endcase
        end
    end

    // A single pixel write is a fill of one; the end is clipped at the strip limit.
    assign limit     = (strip_len_reg < SLOTS_LEN) ? strip_len_reg : SLOTS_LEN;
    assign limit_ext = {{(SUM_W - LEN_W){1'b0}}, limit};
    assign start_ext = {1'b0, first_pix};
    assign end_sum   = start_ext + ((req_type == REQ_SET) ? SUM_W'(1) : {1'b0, run_len});
    assign end_val   = (end_sum > limit_ext) ? limit : end_sum[LEN_W-1:0];

    assign status.write_ok  = (order_reg != ORDER_UNUSED) && (start_ext < limit_ext)
                              && (end_sum > start_ext);
    assign status.fill_last = ({1'b0, cnt_reg} + (CNT_W + 1)'(1)) == {1'b0, end_reg};
    assign status.show_last = (cnt_reg == LAST_SLOT);
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = first_pix[CNT_W-1:0];
        end
        else if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            word_reg <= pack_word(order_reg, red_lvl, green_lvl, blue_lvl, white_lvl);
            end_reg  <= end_val[CNT_W-1:0];
        end
    end

    assign addr = cnt_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.fill_we)
        begin
            mem[addr] <= word_reg;
        end
        if (cmd.show_rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Words never written since reset or the last clear read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_valid)
            begin
                valid_reg <= '0;
            end
            else if (cmd.fill_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (cmd.show_rd)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.show_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.show_ld)
        begin
            out_data_reg <= rd_valid_reg ? rd_data_reg : '0;
            out_wide_reg <= (order_reg == ORDER_GRBW);
            out_last_reg <= status.show_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_wide_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.show_ld |-> !out_valid_reg)
        else $error("output register loaded while a word still waits");

    a_read_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.show_ld |-> $past(cmd.show_rd))
        else $error("output loaded without a preceding store read");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_we |-> ({1'b0, cnt_reg} < {1'b0, end_reg}))
        else $error("fill write past its end");
`endif

endmodule

[src/led_strip_frame_buffer.sv]
// Frame store for an addressable LED strip of up to PIXEL_SLOTS pixels. Requests arrive
// on the s_ stream: set one pixel, fill a run, clear and show, or show. A request is
// taken while the block is idle; a set then writes its single word and a fill writes one
// word per cycle. A show reads the store through its registered read port and then
// loads the output register for each word, waiting while the sink holds m_tready low.
// A clear resets the per-word valid flags in the cycle the request is taken, so clear
// and show costs the same as show. No new request is taken while a fill or show is in
// progress.
module led_strip_frame_buffer #(
    parameter int PIXEL_SLOTS = lsfb_pkg::PIXEL_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsfb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_index[15:0], run_length[31:16], red_level[39:32], green_level[47:40],
    // blue_level[55:48], white_level[63:56]
    input  logic [lsfb_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type[1:0]
    input  logic [lsfb_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_word[31:0]
    output logic [lsfb_pkg::WORD_W-1:0]       m_tdata,
    // wide_word[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import lsfb_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    lsfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    lsfb_datapath #(
        .PIXEL_SLOTS (PIXEL_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[bench/led_strip_frame_buffer_tb.sv]
`timescale 1ns / 100ps

module led_strip_frame_buffer_tb;

    import lsfb_pkg::*;

    localparam int SLOTS       = PIXEL_SLOTS_DEF;
    localparam int SETTLE_WAIT = 2 * SLOTS + 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 50;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   len;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] white;
    } led_req_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              wide;
        logic              last;
    } pixel_out_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [WORD_W-1:0]      m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Predicted frame store and register copies.
    logic [WORD_W-1:0]  pix_store [SLOTS];
    logic [LEN_W-1:0]   strip_len_q = STRIP_LENGTH_RST;
    logic [ORDER_W-1:0] order_q     = CHANNEL_ORDER_RST;

    led_req_t   pend_reqs [$];
    pixel_out_t word_queue [$];

    int  pushed_cnt    = 0;
    int  accepted_cnt  = 0;
    int  show_cnt      = 0;
    int  words_checked = 0;
    int  cfg_writes    = 0;
    int  errors        = 0;
    int  cycle_cnt     = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    int  hold_cnt      = 0;
    bit  hold_done     = 1'b0;
    bit  idle_on       = 1'b1;

    led_strip_frame_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait();
        return idle_on ? $urandom_range(12, 0) : 0;
    endfunction

    // Returns 0 when the channel order has no packing defined.
    function automatic bit pack_pixel(input led_req_t rq, output logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] r32, g32, b32, w32;
        r32 = WORD_W'(rq.red);
        g32 = WORD_W'(rq.green);
        b32 = WORD_W'(rq.blue);
        w32 = WORD_W'(rq.white);
        word = '0;
        if (order_q == ORDER_GRB)
            word = (g32 << 16) | (r32 << 8) | b32;
        else if (order_q == ORDER_RGB)
            word = (r32 << 16) | (g32 << 8) | b32;
        else if (order_q == ORDER_GRBW)
            word = (w32 << 24) | (g32 << 16) | (r32 << 8) | b32;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_frame();
        pixel_out_t po;
        for (int k = 0; k < SLOTS; k++)
        begin
            po.word = pix_store[k];
            po.wide = (order_q == ORDER_GRBW);
            po.last = (k == SLOTS - 1);
            word_queue.push_back(po);
        end
        show_cnt++;
    endtask

    task automatic apply_request(input led_req_t rq);
        int                limit;
        int                stop;
        bit                ok;
        logic [WORD_W-1:0] word;
        limit = (int'(strip_len_q) < SLOTS) ? int'(strip_len_q) : SLOTS;
        ok    = pack_pixel(rq, word);
        case (rq.kind)
            REQ_SET:
                if (ok && int'(rq.idx) < limit)
                    pix_store[rq.idx] = word;
            REQ_FILL:
                if (ok && int'(rq.idx) < limit)
                begin
                    // The end is formed without wrap, then clipped to the strip.
                    stop = int'(rq.idx) + int'(rq.len);
                    if (stop > limit)
                        stop = limit;
                    for (int i = int'(rq.idx); i < stop; i++)
                        pix_store[i] = word;
                end
            REQ_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    pix_store[i] = '0;
                queue_frame();
            end
            default:
                queue_frame();
        endcase
    endtask

    function automatic void check_field(input string name, input logic [WORD_W-1:0] exp_v,
                                        input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Request driver.
    always @(posedge clk)
    begin : drive_requests
        led_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pend_reqs.size() > 0)
            begin
                nxt = pend_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.white, nxt.blue, nxt.green, nxt.red, nxt.len, nxt.idx};
                s_tuser  <= nxt.kind;
                gap_left = draw_wait();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: predicts from each accepted request and checks each result transfer.
    always @(posedge clk)
    begin : watch_outputs
        led_req_t   rq;
        pixel_out_t exp_o;
        if (rst_n)
        begin
            // A request accepted at this edge cannot cause a result at the same edge.
            if (s_tvalid && s_tready)
            begin
                rq.kind  = s_tuser;
                rq.idx   = s_tdata[15:0];
                rq.len   = s_tdata[31:16];
                rq.red   = s_tdata[39:32];
                rq.green = s_tdata[47:40];
                rq.blue  = s_tdata[55:48];
                rq.white = s_tdata[63:56];
                apply_request(rq);
                accepted_cnt++;
            end
            if (m_tvalid && m_tready)
            begin
                if (word_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel word, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    exp_o = word_queue.pop_front();
                    check_field("pixel_word", exp_o.word, m_tdata);
                    check_field("wide_word", WORD_W'(exp_o.wide), WORD_W'(m_tuser));
                    check_field("last_word", WORD_W'(exp_o.last), WORD_W'(m_tlast));
                    words_checked++;
                end
                stall_left = draw_wait();
            end
            else if (stall_left > 0)
                stall_left--;
        end
        m_tready <= rst_n && (hold_cnt == 0) && (stall_left == 0);
    end

    // Long sink hold-off, once, while a show is draining and requests keep coming.
    always @(posedge clk)
    begin
        if (!hold_done && accepted_cnt >= 60 && word_queue.size() > 32
            && pend_reqs.size() > 0)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic [REQ_W-1:0] kind, input int idx, input int len,
                            input int red, input int green, input int blue, input int white);
        led_req_t rq;
        rq.kind  = kind;
        rq.idx   = IDX_W'(idx);
        rq.len   = IDX_W'(len);
        rq.red   = LEVEL_W'(red);
        rq.green = LEVEL_W'(green);
        rq.blue  = LEVEL_W'(blue);
        rq.white = LEVEL_W'(white);
        pend_reqs.push_back(rq);
        pushed_cnt++;
    endtask

    task automatic push_random_req();
        int               k;
        int               idx;
        int               len;
        logic [REQ_W-1:0] kind;
        k = $urandom_range(99, 0);
        if (k < 45)
            kind = REQ_SET;
        else if (k < 75)
            kind = REQ_FILL;
        else if (k < 90)
            kind = REQ_SHOW;
        else
            kind = REQ_CLEAR;
        idx = ($urandom_range(99, 0) < 85) ? $urandom_range(70, 0) : $urandom_range(65535, 0);
        k = $urandom_range(99, 0);
        if (k < 60)
            len = $urandom_range(8, 0);
        else if (k < 85)
            len = $urandom_range(70, 0);
        else
            len = $urandom_range(65535, 0);
        push_req(kind, idx, len, $urandom_range(255, 0), $urandom_range(255, 0),
                 $urandom_range(255, 0), $urandom_range(255, 0));
    endtask

    // Waits until every request has been taken and every word has come out, then lets
    // a trailing fill finish.
    task automatic settle();
        do
            @(posedge clk);
        while (accepted_cnt != pushed_cnt || word_queue.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STRIP_LENGTH)
            strip_len_q = data;
        else
            order_q = data[ORDER_W-1:0];
        cfg_writes++;
    endtask

    initial
    begin
        int                 strips [8];
        logic [ORDER_W-1:0] orders [8];
        for (int i = 0; i < SLOTS; i++)
            pix_store[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: 64 pixels, GRB.
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        push_req(REQ_SET, 0, 0, 255, 255, 255, 255);
        push_req(REQ_SET, 63, 0, 8'h12, 8'h34, 8'h56, 8'hff);
        push_req(REQ_SET, 64, 0, 8'haa, 8'hbb, 8'hcc, 8'hdd);
        push_req(REQ_SET, 65535, 0, 8'h11, 8'h22, 8'h33, 8'h44);
        push_req(REQ_FILL, 10, 0, 8'h01, 8'h02, 8'h03, 8'h04);
        push_req(REQ_FILL, 20, 3, 8'h5a, 8'ha5, 8'h3c, 8'hc3);
        // Run that would wrap a 16-bit end index.
        push_req(REQ_FILL, 60, 65535, 8'h80, 8'h40, 8'h20, 8'h10);
        push_req(REQ_FILL, 65535, 65535, 8'hff, 8'hff, 8'hff, 8'hff);
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        push_req(REQ_CLEAR, 65535, 65535, 255, 255, 255, 255);
        push_req(REQ_SET, 2, 0, 8'h9e, 8'h61, 8'h7f, 8'h00);
        push_req(REQ_SHOW, 65535, 65535, 255, 255, 255, 255);
        settle();

        write_reg(CFG_CHANNEL_ORDER, CFG_DATA_W'(ORDER_RGB));
        write_reg(CFG_STRIP_LENGTH, 7'd10);
        push_req(REQ_SET, 9, 0, 8'hc0, 8'h0c, 8'h30, 8'h03);
        push_req(REQ_SET, 10, 0, 8'hff, 8'hff, 8'hff, 8'hff);
        push_req(REQ_FILL, 5, 100, 8'h21, 8'h43, 8'h65, 8'h87);
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        settle();

        write_reg(CFG_CHANNEL_ORDER, CFG_DATA_W'(ORDER_GRBW));
        write_reg(CFG_STRIP_LENGTH, 7'd127);
        push_req(REQ_SET, 63, 0, 8'h01, 8'h02, 8'h03, 8'hff);
        push_req(REQ_FILL, 30, 5, 8'h44, 8'h55, 8'h66, 8'h80);
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        settle();

        // The unused order packs nothing, so the store must stay as it was.
        write_reg(CFG_CHANNEL_ORDER, CFG_DATA_W'(ORDER_UNUSED));
        push_req(REQ_SET, 0, 0, 8'hde, 8'had, 8'hbe, 8'hef);
        push_req(REQ_FILL, 0, 64, 8'hca, 8'hfe, 8'hba, 8'hbe);
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        settle();

        write_reg(CFG_CHANNEL_ORDER, CFG_DATA_W'(ORDER_GRB));
        write_reg(CFG_STRIP_LENGTH, 7'd0);
        push_req(REQ_SET, 0, 0, 8'h77, 8'h77, 8'h77, 8'h77);
        push_req(REQ_FILL, 0, 5, 8'h66, 8'h66, 8'h66, 8'h66);
        push_req(REQ_SHOW, 0, 0, 0, 0, 0, 0);
        settle();

        // Random phases, each under its own settings.
        strips = '{64, 1, 63, 127, 0, $urandom_range(62, 2), $urandom_range(126, 65), 64};
        orders = '{ORDER_GRB, ORDER_RGB, ORDER_GRBW, ORDER_UNUSED,
                   ORDER_GRBW, ORDER_RGB, ORDER_GRB, ORDER_GRBW};
        for (int p = 0; p < 8; p++)
        begin
            idle_on = (p % 3 != 1);
            write_reg(CFG_STRIP_LENGTH, CFG_DATA_W'(strips[p]));
            // Upper data bits are don't-care for the order register.
            write_reg(CFG_CHANNEL_ORDER,
                      CFG_DATA_W'(($urandom_range(31, 0) << ORDER_W) | orders[p]));
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_req();
            settle();
        end

        $display("Covered %0d requests with %0d shows and %0d checked pixel words,",
                 accepted_cnt, show_cnt, words_checked);
        $display("over %0d register writes across all channel orders and strip lengths 0..127.",
                 cfg_writes);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
